// ===== hdl/dtp_pkg.sv =====
package dtp_pkg;

  // Field widths
  localparam int CharW  = 8;
  localparam int NsW    = 64;
  localparam int FracW  = 30;
  localparam int FcntW  = 4;
  localparam int CountW = 8;

  // Characters and limits
  localparam logic [CharW-1:0]  DotChar   = 8'h2E;
  localparam logic [FcntW-1:0]  FracMax   = 4'd9;
  localparam logic [FcntW-1:0]  FracSat   = 4'd10;
  localparam logic [FcntW-1:0]  FracMilli = 4'd3;
  localparam logic [FcntW-1:0]  FracMicro = 4'd6;
  localparam logic [FcntW-1:0]  FracNano  = 4'd9;
  localparam logic [FcntW-1:0]  FracNone  = 4'd0;
  localparam logic [CountW-1:0] CountMax  = 8'd255;

  // Scale factors for the fraction
  localparam logic [19:0] NsPerMs = 20'd1000000;
  localparam logic [9:0]  NsPerUs = 10'd1000;

  // One seconds digit expressed in nanoseconds
  function automatic logic [NsW-1:0] digit_ns(input logic [3:0] d);
    logic [NsW-1:0] r;
    case (d)
      4'd0: r = 64'd0;
      4'd1: r = 64'd1000000000;
      4'd2: r = 64'd2000000000;
      4'd3: r = 64'd3000000000;
      4'd4: r = 64'd4000000000;
      4'd5: r = 64'd5000000000;
      4'd6: r = 64'd6000000000;
      4'd7: r = 64'd7000000000;
      4'd8: r = 64'd8000000000;
      4'd9: r = 64'd9000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/dtp_char_if.sv =====
interface dtp_char_if
  import dtp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

// ===== hdl/dtp_result_if.sv =====
interface dtp_result_if
  import dtp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NsW-1:0]    nanoseconds;
  logic              invalid;
  logic [CharW-1:0]  stop_char;
  logic [CountW-1:0] consumed;

  modport source (output valid, output nanoseconds, output invalid, output stop_char,
                  output consumed, input ready);
  modport sink   (input valid, input nanoseconds, input invalid, input stop_char,
                  input consumed, output ready);
endinterface

// ===== hdl/decimal_timestamp_parser.sv =====
// Decimal timestamp parser.
// char_i takes one ASCII character per transaction. Digits build the integer
// seconds; one '.' opens a fraction of 0, 3, 6 or 9 digits. Any other
// character ends the token and yields one transaction on result_o: the time
// in nanoseconds (modulo 2^64, zero when invalid), the invalid flag, the
// stop character and the saturating count of characters before it.
// Throughput: one character per cycle. Each character updates the token
// state in the cycle it is accepted; the seconds value is kept already
// scaled to nanoseconds (times ten as a shift-add plus a digit table), so
// the stop path is one narrow constant multiply and one 64-bit add.
// Latency: the result is valid the cycle after the stop character is taken.
// The result sits in a single output register. While it waits, char_i stays
// ready if result_o.ready is high in the same cycle; if the receiver stalls,
// char_i drops ready until the result is taken.
// Reset clears the token state and the output valid; the block then waits
// for the first character of a new token.
module decimal_timestamp_parser
  import dtp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dtp_char_if.sink     char_i,
  dtp_result_if.source result_o
);

  // Token state
  logic              in_frac_q,  in_frac_d;
  logic [NsW-1:0]    ns_acc_q,   ns_acc_d;
  logic [FracW-1:0]  frac_acc_q, frac_acc_d;
  logic [FcntW-1:0]  frac_cnt_q, frac_cnt_d;
  logic [CountW-1:0] char_cnt_q, char_cnt_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [NsW-1:0]    out_ns_q;
  logic              out_bad_q;
  logic [CharW-1:0]  out_stop_q;
  logic [CountW-1:0] out_cnt_q;

  logic             in_fire;
  logic             is_digit, is_dot, is_stop;
  logic [3:0]       digit;
  logic             bad;
  logic [FracW-1:0] frac_scaled;
  logic [NsW-1:0]   ns_result;

  assign char_i.ready = !out_valid_q || result_o.ready;
  assign in_fire      = char_i.valid && char_i.ready;

  // Character classes
  assign digit    = char_i.char_in[3:0];
  assign is_digit = (char_i.char_in[7:4] == 4'h3) && (digit < 4'd10);
  assign is_dot   = (char_i.char_in == DotChar);
  assign is_stop  = !is_digit && !(!in_frac_q && is_dot);

  // Result from the stored token
  always_comb begin
    bad = (frac_cnt_q > FracMax) ||
          !((frac_cnt_q == FracNone) || (frac_cnt_q == FracMilli) ||
            (frac_cnt_q == FracMicro) || (frac_cnt_q == FracNano));
    case (frac_cnt_q)
      FracMilli: frac_scaled = FracW'(frac_acc_q[9:0]) * FracW'(NsPerMs);
      FracMicro: frac_scaled = FracW'(frac_acc_q[19:0]) * FracW'(NsPerUs);
      FracNano:  frac_scaled = frac_acc_q;
      default:   frac_scaled = '0;
    endcase
    ns_result = bad ? '0 : ns_acc_q + NsW'(frac_scaled);
  end

  // Token state update
  always_comb begin
    in_frac_d  = in_frac_q;
    ns_acc_d   = ns_acc_q;
    frac_acc_d = frac_acc_q;
    frac_cnt_d = frac_cnt_q;
    char_cnt_d = char_cnt_q;
    if (in_fire) begin
      if (is_stop) begin
        in_frac_d  = 1'b0;
        ns_acc_d   = '0;
        frac_acc_d = '0;
        frac_cnt_d = '0;
        char_cnt_d = '0;
      end else begin
        if (char_cnt_q != CountMax) begin
          char_cnt_d = char_cnt_q + 1'b1;
        end
        if (!is_digit) begin
          in_frac_d = 1'b1;
        end else if (!in_frac_q) begin
          ns_acc_d = (ns_acc_q << 3) + (ns_acc_q << 1) + digit_ns(digit);
        end else begin
          if (frac_cnt_q < FracMax) begin
            frac_acc_d = (frac_acc_q << 3) + (frac_acc_q << 1) + FracW'(digit);
          end
          if (frac_cnt_q < FracSat) begin
            frac_cnt_d = frac_cnt_q + 1'b1;
          end
        end
      end
    end
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && is_stop) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frac_q   <= 1'b0;
      ns_acc_q    <= '0;
      frac_acc_q  <= '0;
      frac_cnt_q  <= '0;
      char_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frac_q   <= in_frac_d;
      ns_acc_q    <= ns_acc_d;
      frac_acc_q  <= frac_acc_d;
      frac_cnt_q  <= frac_cnt_d;
      char_cnt_q  <= char_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded on the stop character
  always_ff @(posedge clk_i) begin
    if (in_fire && is_stop) begin
      out_ns_q   <= ns_result;
      out_bad_q  <= bad;
      out_stop_q <= char_i.char_in;
      out_cnt_q  <= char_cnt_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.nanoseconds = out_ns_q;
  assign result_o.invalid     = out_bad_q;
  assign result_o.stop_char   = out_stop_q;
  assign result_o.consumed    = out_cnt_q;

  // Checks
  a_stop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_stop) |=> out_valid_q)
    else $error("stop character did not produce a result");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_ns_q == '0))
    else $error("invalid result carries a nonzero value");

  a_token_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_stop) |=> (char_cnt_q == '0 && frac_cnt_q == '0 && !in_frac_q))
    else $error("token state not cleared after stop character");

  a_frac_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_cnt_q <= FracSat)
    else $error("fraction digit count above saturation");

endmodule

// ===== tb/sv/tb_decimal_timestamp_parser.sv =====
`timescale 1ns / 1ps

module tb_decimal_timestamp_parser;
  import dtp_pkg::*;

  localparam int          NumRandom     = 1450;
  localparam int          WatchdogLimit = 2000;
  localparam int          HoldCycles    = 300;
  localparam int          FracStep      = 3;
  localparam logic [63:0] NsPerSec      = 64'd1000000000;

  // One parsed timestamp as it leaves the block
  typedef struct packed {
    logic [NsW-1:0]    ns;
    logic              inval;
    logic [CharW-1:0]  stop;
    logic [CountW-1:0] count;
  } stamp_t;

  // Directed stimulus: a character, how often it repeats, and, on a stop
  // character, an optional hand-written result
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic [15:0]      reps;
    logic             typed;
    stamp_t           want;
  } row_t;

  localparam int NumDir = 28;
  localparam row_t DirTab [NumDir] = '{
    // bare stop character, empty token
    '{8'h20, 16'd1, 1'b1, '{64'd0, 1'b0, 8'h20, 8'd0}},
    // empty integer part, one fraction digit, NUL stop
    '{8'h2E, 16'd1, 1'b0, '0},
    '{8'h35, 16'd1, 1'b0, '0},
    '{8'h00, 16'd1, 1'b1, '{64'd0, 1'b1, 8'h00, 8'd2}},
    // dot with no digits
    '{8'h31, 16'd1, 1'b0, '0},
    '{8'h32, 16'd1, 1'b0, '0},
    '{8'h2E, 16'd1, 1'b0, '0},
    '{8'h2C, 16'd1, 1'b1, '{64'd12000000000, 1'b0, 8'h2C, 8'd3}},
    // milliseconds, ended by a second dot
    '{8'h37, 16'd1, 1'b0, '0},
    '{8'h2E, 16'd1, 1'b0, '0},
    '{8'h31, 16'd1, 1'b0, '0},
    '{8'h32, 16'd1, 1'b0, '0},
    '{8'h33, 16'd1, 1'b0, '0},
    '{8'h2E, 16'd1, 1'b1, '{64'd7123000000, 1'b0, 8'h2E, 8'd5}},
    // microseconds only
    '{8'h2E, 16'd1, 1'b0, '0},
    '{8'h34, 16'd6, 1'b0, '0},
    '{8'h5A, 16'd1, 1'b1, '{64'd444444000, 1'b0, 8'h5A, 8'd7}},
    // stop just below '0'
    '{8'h38, 16'd1, 1'b0, '0},
    '{8'h2F, 16'd1, 1'b1, '{64'd8000000000, 1'b0, 8'h2F, 8'd1}},
    // seconds wrap, nanoseconds, stop 0xFF
    '{8'h39, 16'd20, 1'b0, '0},
    '{8'h2E, 16'd1, 1'b0, '0},
    '{8'h39, 16'd9, 1'b0, '0},
    '{8'hFF, 16'd1, 1'b0, '0},
    // long fraction, stop just above '9'
    '{8'h2E, 16'd1, 1'b0, '0},
    '{8'h31, 16'd12, 1'b0, '0},
    '{8'h3A, 16'd1, 1'b1, '{64'd0, 1'b1, 8'h3A, 8'd13}},
    // long token, count saturates
    '{8'h33, 16'd300, 1'b0, '0},
    '{8'h3B, 16'd1, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  dtp_char_if   char_if ();
  dtp_result_if res_if ();

  decimal_timestamp_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_if),
    .result_o (res_if)
  );

  // Parser state tracked by the testbench
  logic              frac_phase;
  logic [63:0]       sec_acc;
  logic [FracW-1:0]  frac_acc;
  logic [FcntW-1:0]  frac_cnt;
  logic [CountW-1:0] tok_len;

  stamp_t stamp_q[$];
  int     err_cnt    = 0;
  int     sent_cnt   = 0;
  int     res_cnt    = 0;
  int     stall_cyc  = 0;
  bit     tx_idle_en = 1'b1;
  bit     rx_idle_en = 1'b1;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit is_digit(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    d = c ^ 8'h30;
    return d < 8'd10;
  endfunction

  function automatic void clear_token();
    frac_phase = 1'b0;
    sec_acc    = '0;
    frac_acc   = '0;
    frac_cnt   = '0;
    tok_len    = '0;
  endfunction

  // Advance the parser by one character; returns 1 with the timestamp on a stop
  function automatic bit parse_step(input logic [CharW-1:0] c, output stamp_t r);
    logic [3:0]  d;
    logic [63:0] frac;
    logic        bad;
    d = 4'(c ^ 8'h30);
    r = '0;
    if (is_digit(c)) begin
      if (!frac_phase) begin
        sec_acc = sec_acc * 64'd10 + 64'(d);
      end else begin
        if (frac_cnt < FracMax) frac_acc = frac_acc * 30'd10 + 30'(d);
        if (frac_cnt < FracSat) frac_cnt = frac_cnt + 1'b1;
      end
      if (tok_len != CountMax) tok_len = tok_len + 1'b1;
      return 1'b0;
    end
    if (!frac_phase && c == DotChar) begin
      frac_phase = 1'b1;
      if (tok_len != CountMax) tok_len = tok_len + 1'b1;
      return 1'b0;
    end
    // stop character
    bad = (frac_cnt > FracMax) || ((int'(frac_cnt) % FracStep) != 0);
    case (frac_cnt)
      FracMilli: frac = 64'(frac_acc) * 64'(NsPerMs);
      FracMicro: frac = 64'(frac_acc) * 64'(NsPerUs);
      FracNano:  frac = 64'(frac_acc);
      default:   frac = '0;
    endcase
    r.ns    = bad ? 64'd0 : sec_acc * NsPerSec + frac;
    r.inval = bad;
    r.stop  = c;
    r.count = tok_len;
    clear_token();
    return 1'b1;
  endfunction

  // Offer one character; returns at the rising edge that accepts it
  task automatic send_char(input logic [CharW-1:0] c, input bit typed, input stamp_t want);
    stamp_t r;
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(99) < 7) begin
      char_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_if.valid   <= 1'b1;
    char_if.char_in <= c;
    do @(posedge clk_i); while (!char_if.ready);
    sent_cnt++;
    if (parse_step(c, r)) stamp_q.push_back(typed ? want : r);
  endtask

  // Stop offering and wait until every timestamp has come out
  task automatic drain();
    @(negedge clk_i);
    char_if.valid <= 1'b0;
    while (stamp_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [CharW-1:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // Any character that ends the current token
  function automatic logic [CharW-1:0] pick_stop();
    logic [CharW-1:0] c;
    if (frac_phase && $urandom_range(9) == 0) return DotChar;
    do c = 8'($urandom_range(255));
    while (is_digit(c) || (!frac_phase && c == DotChar));
    return c;
  endfunction

  // One random token: mostly well-formed, some raw noise
  task automatic gen_token();
    int n_int;
    int n_frac;
    int r;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(255)), 1'b0, '0);
    end else begin
      r = $urandom_range(199);
      n_int = (r == 0) ? $urandom_range(256, 290) :
              (r < 12) ? $urandom_range(19, 24) : $urandom_range(0, 12);
      repeat (n_int) send_char(rand_digit(), 1'b0, '0);
      if ($urandom_range(3) != 0) begin
        send_char(DotChar, 1'b0, '0);
        n_frac = ($urandom_range(9) < 8) ? FracStep * $urandom_range(0, 3)
                                         : $urandom_range(1, 14);
        repeat (n_frac) send_char(rand_digit(), 1'b0, '0);
      end
      send_char(pick_stop(), 1'b0, '0);
    end
  endtask

  // Stimulus and end of run
  initial begin
    int rnd_base;
    bit mid_done;
    mid_done        = 1'b0;
    rst_ni          = 1'b0;
    char_if.valid   = 1'b0;
    char_if.char_in = '0;
    clear_token();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirTab[i]) begin
      repeat (DirTab[i].reps) send_char(DirTab[i].ch, DirTab[i].typed, DirTab[i].want);
    end
    drain();

    rnd_base = sent_cnt;
    while (sent_cnt - rnd_base < NumRandom) begin
      tx_idle_en = !((sent_cnt - rnd_base) >= 600 && (sent_cnt - rnd_base) < 1000);
      if (!mid_done && (sent_cnt - rnd_base) >= NumRandom / 2) begin
        drain();
        mid_done = 1'b1;
      end
      gen_token();
    end
    drain();
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_decimal_timestamp_parser: clean");
    end else begin
      $display("tb_decimal_timestamp_parser: errors");
    end
    $finish;
  end

  // Result side back-pressure: random stalls, one long hold, one quiet stretch
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && res_cnt >= 40) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      rx_idle_en = !(res_cnt >= 80 && res_cnt < 130);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(99) < 7) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest expected timestamp
  always @(posedge clk_i) begin
    stamp_t want;
    if (res_if.valid && res_if.ready) begin
      res_cnt++;
      if (stamp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result ns=%0d invalid=%0d stop=%h consumed=%0d", $realtime,
                 res_if.nanoseconds, res_if.invalid, res_if.stop_char, res_if.consumed);
      end else begin
        want = stamp_q.pop_front();
        if (res_if.nanoseconds !== want.ns) begin
          err_cnt++;
          $display("%0t: nanoseconds expected %0d actual %0d", $realtime, want.ns,
                   res_if.nanoseconds);
        end
        if (res_if.invalid !== want.inval) begin
          err_cnt++;
          $display("%0t: invalid expected %0d actual %0d", $realtime, want.inval,
                   res_if.invalid);
        end
        if (res_if.stop_char !== want.stop) begin
          err_cnt++;
          $display("%0t: stop_char expected %h actual %h", $realtime, want.stop,
                   res_if.stop_char);
        end
        if (res_if.consumed !== want.count) begin
          err_cnt++;
          $display("%0t: consumed expected %0d actual %0d", $realtime, want.count,
                   res_if.consumed);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cyc = 0;
    end else begin
      stall_cyc++;
    end
    if (stall_cyc >= WatchdogLimit) begin
      $display("%0t: watchdog, no transaction for %0d cycles, %0d results pending",
               $realtime, stall_cyc, stamp_q.size());
      $display("tb_decimal_timestamp_parser: errors");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hdl/dtp_pkg.sv
hdl/dtp_char_if.sv
hdl/dtp_result_if.sv
hdl/decimal_timestamp_parser.sv
tb/sv/tb_decimal_timestamp_parser.sv
